>>> rtl/rtree_node_split_4d_defines.svh
// assertion macros for the r-tree node split block
// used by rtree_node_split_4d, no other dependencies
`ifndef RTREE_NODE_SPLIT_4D_DEFINES_SVH
`define RTREE_NODE_SPLIT_4D_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RTNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RTNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rtns_pkg.sv
// types and constants for the r-tree node split block
// no dependencies
package rtns_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int COORD_BITS  = 15;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W       = COORD_BITS + 1;
  localparam int VOL_W       = 64;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] lo;
    coord_t [3:0] hi;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic [14:0] lo_a;
    logic [14:0] lo_b;
    logic [14:0] lo_c;
    logic [14:0] lo_d;
    logic [14:0] hi_a;
    logic [14:0] hi_b;
    logic [14:0] hi_c;
    logic [14:0] hi_d;
    logic        final_entry;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  entry_number;
    logic        goes_right;
    logic [14:0] out_lo_a;
    logic [14:0] out_lo_b;
    logic [14:0] out_lo_c;
    logic [14:0] out_lo_d;
    logic [14:0] out_hi_a;
    logic [14:0] out_hi_b;
    logic [14:0] out_hi_c;
    logic [14:0] out_hi_d;
    logic        run_end;
  } out_beat_t;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

endpackage

>>> rtl/rtns_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rtns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rtree_node_split_4d.sv
// r-tree node split top level: box store, pair search and group assignment
// depends on rtns_pkg, rtns_ram and rtree_node_split_4d_defines.svh
//
// usage
//   in channel: one 4d box per beat, numbered from 1; final_entry closes the
//   node and starts the split. boxes past the node capacity are dropped.
//   out channel: one assignment beat per held entry (seeds first, then the
//   rest in ascending order), then the left box beat and the right box beat,
//   the last one flagged with run_end.
//   pacing: loading holds in_ready high; the split is set by the single
//   box-store read port and the shared two-stage volume unit: a pair
//   search over n*(n-1)/2 pairs, the seed fetch, a scan that skips the
//   seeds, the remaining entries one by one, then the result beats as
//   out_ready allows.
//   in_ready is low for the whole split.
//   reset: synchronous; clears the entry count and marks and empties the
//   output register. the box store is not cleared.
//   stall: a result waits in the output register; the split pauses until
//   it is taken, and loading resumes while the last beat still waits.
module rtree_node_split_4d (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtns_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtns_pkg::out_beat_t out_data
);
  import rtns_pkg::*;

  `include "rtree_node_split_4d_defines.svh"

  typedef enum logic [4:0] {
    S_LOAD, S_WAIT,
    S_R0, S_G0, S_E1,
    S_RI, S_GI, S_VI, S_RJ, S_GJ, S_VJ, S_WS,
    S_RSL, S_GSL, S_VSL, S_RSR, S_GSR, S_VSR, S_ESL, S_ESR,
    S_SCAN, S_GE, S_VUL, S_VUR, S_EA, S_ELB, S_ERB
  } state_t;

  state_t                 state_r, ret_r;
  logic                   wait_r;
  logic [CNT_W-1:0]       cnt_r, i_r, j_r, lcnt_r, rcnt_r;
  logic [CNT_W-1:0]       seed_l_r, seed_r_r;
  logic [MAX_ENTRIES-1:0] marks_r;
  box_t                   bi_r, bj_r, lbox_r, rbox_r, vbox_r;
  logic signed [VOL_W-1:0] vi_r, vj_r, vl_r, vr_r, vul_r, best_r;
  logic signed [31:0]     p01_r, p23_r;
  logic signed [VOL_W-1:0] vol_r;
  logic                   goes_r;
  logic                   out_valid_r;
  out_beat_t              out_data_r;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  box_t                   ram_rdata, in_box;
  logic [BOX_W-1:0]       ram_rdata_raw;
  logic                   accept, slot_free, emit;
  logic [CNT_W-1:0]       cnt_after;
  logic signed [VOL_W-1:0] waste, dl, dr;
  logic signed [EXT_W-1:0] ext [4];

  function automatic box_t box_union(box_t a, box_t b);
    box_t u;
    for (int k = 0; k < 4; k++) begin
      u.lo[k] = (a.lo[k] < b.lo[k]) ? a.lo[k] : b.lo[k];
      u.hi[k] = (a.hi[k] > b.hi[k]) ? a.hi[k] : b.hi[k];
    end
    return u;
  endfunction

  function automatic out_beat_t row(logic kind, logic [5:0] num, logic right,
                                    box_t b, logic last);
    out_beat_t r;
    r.kind         = kind;
    r.entry_number = num;
    r.goes_right   = right;
    r.out_lo_a     = 15'(b.lo[0]);
    r.out_lo_b     = 15'(b.lo[1]);
    r.out_lo_c     = 15'(b.lo[2]);
    r.out_lo_d     = 15'(b.lo[3]);
    r.out_hi_a     = 15'(b.hi[0]);
    r.out_hi_b     = 15'(b.hi[1]);
    r.out_hi_c     = 15'(b.hi[2]);
    r.out_hi_d     = 15'(b.hi[3]);
    r.run_end      = last;
    return r;
  endfunction

  assign in_box.lo[0] = COORD_BITS'(in_data.lo_a);
  assign in_box.lo[1] = COORD_BITS'(in_data.lo_b);
  assign in_box.lo[2] = COORD_BITS'(in_data.lo_c);
  assign in_box.lo[3] = COORD_BITS'(in_data.lo_d);
  assign in_box.hi[0] = COORD_BITS'(in_data.hi_a);
  assign in_box.hi[1] = COORD_BITS'(in_data.hi_b);
  assign in_box.hi[2] = COORD_BITS'(in_data.hi_c);
  assign in_box.hi[3] = COORD_BITS'(in_data.hi_d);

  assign in_ready  = (state_r == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign ram_we    = accept && (cnt_r < CNT_W'(MAX_ENTRIES));
  assign cnt_after = ram_we ? cnt_r + 1'b1 : cnt_r;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = slot_free && (state_r == S_E1 || state_r == S_ESL ||
                                   state_r == S_ESR || state_r == S_EA ||
                                   state_r == S_ELB || state_r == S_ERB);
  assign ram_rdata = box_t'(ram_rdata_raw);

  always_comb begin
    case (state_r)
      S_RI:    ram_raddr = i_r[IDX_W-1:0];
      S_RJ:    ram_raddr = j_r[IDX_W-1:0];
      S_RSL:   ram_raddr = seed_l_r[IDX_W-1:0];
      S_RSR:   ram_raddr = seed_r_r[IDX_W-1:0];
      S_SCAN:  ram_raddr = i_r[IDX_W-1:0];
      default: ram_raddr = '0;
    endcase
  end

  rtns_ram #(
    .WIDTH(BOX_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[IDX_W-1:0]),
    .wdata(BOX_W'(in_box)),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  // two-stage volume unit on vbox_r
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ext[k] = $signed({1'b0, vbox_r.hi[k]}) - $signed({1'b0, vbox_r.lo[k]});
    end
  end

  always_ff @(posedge clk) begin
    p01_r <= 32'(ext[0]) * 32'(ext[1]);
    p23_r <= 32'(ext[2]) * 32'(ext[3]);
    vol_r <= VOL_W'(p01_r) * VOL_W'(p23_r);
  end

  assign waste = vol_r - vi_r - vj_r;
  assign dl    = vul_r - vl_r;
  assign dr    = vol_r - vr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ret_r       <= S_LOAD;
      wait_r      <= 1'b0;
      cnt_r       <= '0;
      marks_r     <= '0;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            cnt_r <= cnt_after;
            if (in_data.final_entry) begin
              i_r    <= '0;
              best_r <= -64'sd1;
              seed_l_r <= CNT_W'(0);
              seed_r_r <= CNT_W'(1);
              state_r  <= (cnt_after < CNT_W'(2)) ? S_R0 : S_RI;
            end
          end
        end
        S_WAIT: begin
          wait_r <= 1'b1;
          if (wait_r) begin
            state_r <= ret_r;
          end
        end
        S_R0: state_r <= S_G0;
        S_G0: begin
          lbox_r  <= ram_rdata;
          rbox_r  <= '0;
          lcnt_r  <= CNT_W'(1);
          rcnt_r  <= '0;
          state_r <= S_E1;
        end
        S_E1: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_ASSIGN, 6'd1, 1'b0, '0, 1'b0);
            state_r     <= S_ELB;
          end
        end
        S_RI: state_r <= S_GI;
        S_GI: begin
          bi_r    <= ram_rdata;
          vbox_r  <= ram_rdata;
          wait_r  <= 1'b0;
          ret_r   <= S_VI;
          state_r <= S_WAIT;
        end
        S_VI: begin
          vi_r    <= vol_r;
          j_r     <= i_r + 1'b1;
          state_r <= S_RJ;
        end
        S_RJ: state_r <= S_GJ;
        S_GJ: begin
          bj_r    <= ram_rdata;
          vbox_r  <= ram_rdata;
          wait_r  <= 1'b0;
          ret_r   <= S_VJ;
          state_r <= S_WAIT;
        end
        S_VJ: begin
          vj_r    <= vol_r;
          vbox_r  <= box_union(bi_r, bj_r);
          wait_r  <= 1'b0;
          ret_r   <= S_WS;
          state_r <= S_WAIT;
        end
        S_WS: begin
          if (waste > best_r) begin
            best_r   <= waste;
            seed_l_r <= i_r;
            seed_r_r <= j_r;
          end
          if (j_r + 1'b1 < cnt_r) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RJ;
          end else if (i_r + CNT_W'(2) < cnt_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RI;
          end else begin
            state_r <= S_RSL;
          end
        end
        S_RSL: state_r <= S_GSL;
        S_GSL: begin
          lbox_r  <= ram_rdata;
          vbox_r  <= ram_rdata;
          wait_r  <= 1'b0;
          ret_r   <= S_VSL;
          state_r <= S_WAIT;
        end
        S_VSL: begin
          vl_r    <= vol_r;
          state_r <= S_RSR;
        end
        S_RSR: state_r <= S_GSR;
        S_GSR: begin
          rbox_r  <= ram_rdata;
          vbox_r  <= ram_rdata;
          wait_r  <= 1'b0;
          ret_r   <= S_VSR;
          state_r <= S_WAIT;
        end
        S_VSR: begin
          vr_r    <= vol_r;
          lcnt_r  <= CNT_W'(1);
          rcnt_r  <= CNT_W'(1);
          marks_r[seed_l_r[IDX_W-1:0]] <= 1'b1;
          marks_r[seed_r_r[IDX_W-1:0]] <= 1'b1;
          state_r <= S_ESL;
        end
        S_ESL: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_ASSIGN, 6'(seed_l_r + 1'b1), 1'b0, '0, 1'b0);
            state_r     <= S_ESR;
          end
        end
        S_ESR: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_ASSIGN, 6'(seed_r_r + 1'b1), 1'b1, '0, 1'b0);
            i_r         <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (i_r >= cnt_r) begin
            state_r <= S_ELB;
          end else if (marks_r[i_r[IDX_W-1:0]]) begin
            i_r <= i_r + 1'b1;
          end else begin
            state_r <= S_GE;
          end
        end
        S_GE: begin
          bj_r    <= ram_rdata;
          vbox_r  <= box_union(lbox_r, ram_rdata);
          wait_r  <= 1'b0;
          ret_r   <= S_VUL;
          state_r <= S_WAIT;
        end
        S_VUL: begin
          vul_r   <= vol_r;
          vbox_r  <= box_union(rbox_r, bj_r);
          wait_r  <= 1'b0;
          ret_r   <= S_VUR;
          state_r <= S_WAIT;
        end
        S_VUR: begin
          if (dl < dr || (dl == dr && lcnt_r <= rcnt_r)) begin
            lbox_r <= box_union(lbox_r, bj_r);
            vl_r   <= vul_r;
            lcnt_r <= lcnt_r + 1'b1;
            goes_r <= 1'b0;
          end else begin
            rbox_r <= vbox_r;
            vr_r   <= vol_r;
            rcnt_r <= rcnt_r + 1'b1;
            goes_r <= 1'b1;
          end
          state_r <= S_EA;
        end
        S_EA: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_ASSIGN, 6'(i_r + 1'b1), goes_r, '0, 1'b0);
            i_r         <= i_r + 1'b1;
            state_r     <= S_SCAN;
          end
        end
        S_ELB: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_BOX, 6'd0, 1'b0, lbox_r, 1'b0);
            state_r     <= S_ERB;
          end
        end
        S_ERB: begin
          if (slot_free) begin
            out_data_r  <= row(KIND_BOX, 6'd0, 1'b1, rbox_r, 1'b1);
            cnt_r       <= '0;
            marks_r     <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RTNS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_ENTRIES), "entry count past capacity")
  `RTNS_ASSERT_NOW(a_pair_order, state_r == S_WS, j_r > i_r && j_r < cnt_r, "bad pair indices")
  `RTNS_ASSERT_NEXT(a_split_clear, state_r == S_ERB && slot_free, marks_r == '0 && cnt_r == '0, "split did not clear")
  `RTNS_ASSERT_NOW(a_seed_order, state_r == S_ESL, seed_l_r < seed_r_r, "seeds out of order")

endmodule
